// ----- src/dcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS catch-all responder package
// Shared types, command codes and constants of the responder.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int MAX_DATAGRAM_BYTES_DEF = 512;
    localparam int HEADER_BYTES           = 12;
    localparam int QUEUE_DEPTH            = 4;
    localparam int ANSWER_TAIL_BYTES      = 16;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_ABORT  = 2'd1;
    localparam logic [1:0] CMD_ANSWER = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } dcr_cmd_t;

    typedef struct packed {
        logic     valid;
        dcr_cmd_t cmd;
    } dcr_head_t;

    // Bytes of the appended A record following the last question byte.
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] addr);
        logic [7:0] res;
        res = 8'h00;
        case (idx)
            4'd0:    res = 8'hC0;
            4'd1:    res = 8'h0C;
            4'd3:    res = 8'h01;
            4'd5:    res = 8'h01;
            4'd11:   res = 8'h04;
            4'd12:   res = addr[31:24];
            4'd13:   res = addr[23:16];
            4'd14:   res = addr[15:8];
            4'd15:   res = addr[7:0];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- src/dcr_query_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Query channel
// Carries one byte of a received DNS query datagram per transaction.
// ----------------------------------------------------------------------------
interface dcr_query_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface
`default_nettype wire

// ----- src/dcr_reply_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply channel
// Carries one reply byte or an abort marker per transaction.
// ----------------------------------------------------------------------------
interface dcr_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       byte_present;
    logic       reply_done;
    logic       reply_abort;

    modport source (output valid, output reply_byte, output byte_present,
                    output reply_done, output reply_abort, input ready);
    modport sink (input valid, input reply_byte, input byte_present,
                  input reply_done, input reply_abort, output ready);
endinterface
`default_nettype wire

// ----- src/dcr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Responder front end
// Follows the header and question of each query and issues one command per
// byte that produces reply output.
// ----------------------------------------------------------------------------
module dcr_front #(
    parameter int MAX_DATAGRAM_BYTES = dcr_pkg::MAX_DATAGRAM_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    dcr_query_if.sink             query,
    input  wire logic             queue_full,
    output logic                  push,
    output dcr_pkg::dcr_cmd_t     push_cmd
);
    import dcr_pkg::*;

    localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam int SUM_W = POS_W + 9;

    localparam logic [1:0] PH_RECV  = 2'd0;
    localparam logic [1:0] PH_DONE  = 2'd1;
    localparam logic [1:0] PH_ABORT = 2'd2;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] label_reg, label_next;
    logic [POS_W-1:0] qend_reg, qend_next;
    logic             term_reg, term_next;
    logic             qcnt_reg, qcnt_next;
    logic [1:0]       phase_reg, phase_next;

    logic             accept;
    logic             active;
    logic             abort_now;
    logic             complete;
    logic [7:0]       out_data;
    logic [POS_W:0]   qe;
    logic [SUM_W-1:0] nx;

    assign query.ready = !queue_full;
    assign accept      = query.valid && !queue_full;

    assign qe = {1'b0, pos_reg} + (POS_W + 1)'(4);
    assign nx = SUM_W'(pos_reg) + SUM_W'(query.data_byte) + SUM_W'(1);

    always_comb
    begin
        pos_next   = pos_reg;
        label_next = label_reg;
        qend_next  = qend_reg;
        term_next  = term_reg;
        qcnt_next  = qcnt_reg;
        phase_next = phase_reg;
        abort_now  = 1'b0;
        complete   = 1'b0;
        out_data   = query.data_byte;
        push_cmd   = '0;
        push       = 1'b0;
        active     = (phase_reg == PH_RECV) && (pos_reg < POS_W'(MAX_DATAGRAM_BYTES));

        if (active)
        begin
            if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                case (pos_reg)
                    POS_W'(2):
                    begin
                        abort_now = query.data_byte[7];
                        out_data  = 8'h81;
                    end
                    POS_W'(3):  out_data = 8'h80;
                    POS_W'(4):  qcnt_next = (query.data_byte != 8'h00);
                    POS_W'(5):  abort_now = !qcnt_reg && (query.data_byte == 8'h00);
                    POS_W'(6):  out_data = 8'h00;
                    POS_W'(7):  out_data = 8'h01;
                    POS_W'(8):  out_data = 8'h00;
                    POS_W'(9):  out_data = 8'h00;
                    POS_W'(10): out_data = 8'h00;
                    POS_W'(11): out_data = 8'h00;
                    default:    out_data = query.data_byte;
                endcase
            end
            else if (!term_reg)
            begin
                if (pos_reg == label_reg)
                begin
                    if (query.data_byte == 8'h00)
                    begin
                        term_next = 1'b1;
                        if (qe >= (POS_W + 1)'(MAX_DATAGRAM_BYTES))
                            abort_now = 1'b1;
                        else
                            qend_next = qe[POS_W-1:0];
                    end
                    else
                    begin
                        if (nx >= SUM_W'(MAX_DATAGRAM_BYTES))
                            abort_now = 1'b1;
                        else
                            label_next = nx[POS_W-1:0];
                    end
                end
            end
            else if (pos_reg == qend_reg)
            begin
                complete = 1'b1;
            end

            if (abort_now)
                phase_next = PH_ABORT;
            else if (complete)
                phase_next = PH_DONE;
            pos_next = pos_reg + POS_W'(1);

            push          = accept;
            push_cmd.data = abort_now ? 8'h00 : out_data;
            if (abort_now)
                push_cmd.kind = CMD_ABORT;
            else if (complete)
                push_cmd.kind = CMD_ANSWER;
            else
                push_cmd.kind = CMD_BYTE;
        end

        if (query.end_of_datagram)
        begin
            if (phase_next == PH_RECV)
            begin
                push     = accept;
                push_cmd = '{kind: CMD_ABORT, data: 8'h00};
            end
            pos_next   = '0;
            label_next = POS_W'(HEADER_BYTES);
            qend_next  = '0;
            term_next  = 1'b0;
            qcnt_next  = 1'b0;
            phase_next = PH_RECV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            label_reg <= POS_W'(HEADER_BYTES);
            qend_reg  <= '0;
            term_reg  <= 1'b0;
            qcnt_reg  <= 1'b0;
            phase_reg <= PH_RECV;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            label_reg <= label_next;
            qend_reg  <= qend_next;
            term_reg  <= term_next;
            qcnt_reg  <= qcnt_next;
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/dcr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Responder command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module dcr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dcr_pkg::dcr_cmd_t  push_cmd,
    output logic                    full,
    input  wire logic               pop,
    output dcr_pkg::dcr_head_t      head
);
    import dcr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dcr_cmd_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = mem[rd_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_next  = push ? wr_reg + PTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/dcr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Responder back end
// Turns queued commands into reply transactions and appends the A record.
// ----------------------------------------------------------------------------
module dcr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dcr_pkg::dcr_head_t head,
    output logic                    pop,
    input  wire logic [31:0]        answer_address,
    dcr_reply_if.source             reply
);
    import dcr_pkg::*;

    logic       valid_reg, valid_next;
    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       present_reg, present_next;
    logic       done_reg, done_next;
    logic       abort_reg, abort_next;
    logic       slot_free;

    assign slot_free = !valid_reg || reply.ready;
    assign pop       = slot_free && !busy_reg && head.valid;

    always_comb
    begin
        valid_next   = valid_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        byte_next    = byte_reg;
        present_next = present_reg;
        done_next    = done_reg;
        abort_next   = abort_reg;

        if (slot_free)
        begin
            if (busy_reg)
            begin
                valid_next   = 1'b1;
                byte_next    = answer_byte(idx_reg, answer_address);
                present_next = 1'b1;
                done_next    = (idx_reg == 4'(ANSWER_TAIL_BYTES - 1));
                abort_next   = 1'b0;
                busy_next    = (idx_reg != 4'(ANSWER_TAIL_BYTES - 1));
                idx_next     = idx_reg + 4'd1;
            end
            else if (head.valid)
            begin
                valid_next = 1'b1;
                done_next  = 1'b0;
                case (head.cmd.kind)
                    CMD_ABORT:
                    begin
                        byte_next    = 8'h00;
                        present_next = 1'b0;
                        abort_next   = 1'b1;
                    end
                    CMD_ANSWER:
                    begin
                        byte_next    = head.cmd.data;
                        present_next = 1'b1;
                        abort_next   = 1'b0;
                        busy_next    = 1'b1;
                        idx_next     = 4'd0;
                    end
                    default:
                    begin
                        byte_next    = head.cmd.data;
                        present_next = 1'b1;
                        abort_next   = 1'b0;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        present_reg <= present_next;
        done_reg    <= done_next;
        abort_reg   <= abort_next;
    end

    assign reply.valid        = valid_reg;
    assign reply.reply_byte   = byte_reg;
    assign reply.byte_present = present_reg;
    assign reply.reply_done   = done_reg;
    assign reply.reply_abort  = abort_reg;

endmodule
`default_nettype wire

// ----- src/dns_catchall_responder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS catch-all responder
// Streams a reply to each DNS query that answers with one IPv4 address.
// ----------------------------------------------------------------------------
// Query bytes are accepted at one per cycle while the queue is not full.
// Each byte that yields reply output becomes one command in a four-entry
// queue, and the output stage emits one reply transaction per cycle while
// the reply side is ready. The last question byte expands into seventeen
// reply transactions; while the output stage sends them, the queue takes up
// to four further commands before the query side is held back. The answer
// address is written and read back through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module dns_catchall_responder_core #(
    parameter int MAX_DATAGRAM_BYTES = dcr_pkg::MAX_DATAGRAM_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dcr_query_if.sink        query,
    dcr_reply_if.source      reply,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dcr_pkg::*;

    logic        addr_reg, addr_next;
    logic        queue_full;
    logic        push;
    dcr_cmd_t    push_cmd;
    logic        pop;
    dcr_head_t   head;
    logic [31:0] answer_address_reg, answer_address_next;

    assign pready = 1'b1;

    always_comb
    begin
        answer_address_next = answer_address_reg;
        if (psel && penable && pwrite && !paddr[2])
            answer_address_next = pwdata;
        addr_next = 1'b0;
        prdata    = paddr[2] ? 32'h0 : answer_address_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_address_reg <= '0;
            addr_reg           <= 1'b0;
        end
        else
        begin
            answer_address_reg <= answer_address_next;
            addr_reg           <= addr_next;
        end
    end

    dcr_front #(
        .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .queue_full (queue_full || addr_reg),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head)
    );

    dcr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .answer_address (answer_address_reg),
        .reply          (reply)
    );

endmodule
`default_nettype wire

// ----- bench/dcr_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS responder reply checker
// Watches the query, reply and APB channels of the responder, predicts the
// reply transactions that each accepted query byte should produce and
// compares every accepted reply transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module dcr_reply_checker #(
    parameter int         MAX_BYTES  = 512,
    parameter logic [2:0] ANSWER_REG = 3'd0
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dcr_query_if             query,
    dcr_reply_if             reply,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               errors,
    output int               pending
);

    localparam logic [7:0]  FLAGS_HI      = 8'h81;
    localparam logic [7:0]  FLAGS_LO      = 8'h80;
    localparam logic [7:0]  ANCOUNT_LO    = 8'h01;
    localparam logic [7:0]  COUNT_CLEARED = 8'h00;
    localparam logic [95:0] A_RECORD_HEAD = 96'hC00C_0001_0001_0000_0000_0004;
    localparam int          MAX_SHOWN     = 10;

    typedef enum logic [1:0] {PH_RECEIVING, PH_DONE, PH_ABORTED} phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       done;
        logic       abort;
    } reply_t;

    reply_t     reply_due[$];
    logic [31:0] answer_addr;
    logic [9:0] pos;
    logic [9:0] next_label;
    logic [9:0] question_end;
    logic       term_seen;
    logic       qd_hi_nonzero;
    phase_t     phase;

    function automatic reply_t reply_of(input logic [7:0] b, input logic p,
                                        input logic d, input logic a);
        reply_t r;
        r.data    = b;
        r.present = p;
        r.done    = d;
        r.abort   = a;
        return r;
    endfunction

    task automatic restart_datagram();
        pos           = '0;
        next_label    = 10'(dcr_pkg::HEADER_BYTES);
        question_end  = '0;
        term_seen     = 1'b0;
        qd_hi_nonzero = 1'b0;
        phase         = PH_RECEIVING;
    endtask

    task automatic predict_reply(input logic [7:0] b, input logic last);
        reply_t     burst[$];
        logic [7:0] ob;
        logic       abort_now;
        logic       complete;
        logic [10:0] nx;
        burst.delete();
        if (phase == PH_RECEIVING && pos < MAX_BYTES) begin
            ob        = b;
            abort_now = 1'b0;
            complete  = 1'b0;
            if (pos < dcr_pkg::HEADER_BYTES) begin
                case (pos)
                    2: begin
                        abort_now = b[7];
                        ob        = FLAGS_HI;
                    end
                    3: ob = FLAGS_LO;
                    4: qd_hi_nonzero = (b != 8'h00);
                    5: abort_now = !qd_hi_nonzero && (b == 8'h00);
                    7: ob = ANCOUNT_LO;
                    6, 8, 9, 10, 11: ob = COUNT_CLEARED;
                    default: ;
                endcase
            end else if (!term_seen) begin
                if (pos == next_label) begin
                    if (b == 8'h00) begin
                        term_seen = 1'b1;
                        nx = pos + 11'd4;
                        if (nx >= MAX_BYTES)
                            abort_now = 1'b1;
                        else
                            question_end = nx[9:0];
                    end else begin
                        nx = pos + b + 11'd1;
                        if (nx >= MAX_BYTES)
                            abort_now = 1'b1;
                        else
                            next_label = nx[9:0];
                    end
                end
            end else if (pos == question_end) begin
                complete = 1'b1;
            end

            if (abort_now) begin
                burst.push_back(reply_of(8'h00, 1'b0, 1'b0, 1'b1));
                phase = PH_ABORTED;
            end else begin
                burst.push_back(reply_of(ob, 1'b1, 1'b0, 1'b0));
                if (complete) begin
                    for (int i = 0; i < 12; i++)
                        burst.push_back(reply_of(A_RECORD_HEAD[95 - 8 * i -: 8],
                                                 1'b1, 1'b0, 1'b0));
                    for (int k = 0; k < 4; k++)
                        burst.push_back(reply_of(answer_addr[31 - 8 * k -: 8],
                                                 1'b1, k == 3, 1'b0));
                    phase = PH_DONE;
                end
            end
            pos = pos + 10'd1;
        end

        // If a datagram ends before its reply is complete, its last byte yields only an abort.
        if (last) begin
            if (phase == PH_RECEIVING) begin
                burst.delete();
                burst.push_back(reply_of(8'h00, 1'b0, 1'b0, 1'b1));
            end
            restart_datagram();
        end

        foreach (burst[i])
            reply_due.push_back(burst[i]);
    endtask

    task automatic flag_mismatch(input string what, input reply_t want,
                                 input reply_t got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t: reply %s: expected byte %h present %b done %b abort %b,",
                     $time, what, want.data, want.present, want.done, want.abort,
                     " got byte %h present %b done %b abort %b",
                     got.data, got.present, got.done, got.abort);
    endtask

    always @(posedge clk or negedge rst_n) begin
        reply_t got;
        reply_t want;
        if (!rst_n) begin
            errors      = 0;
            answer_addr = '0;
            reply_due.delete();
            restart_datagram();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ANSWER_REG)
                answer_addr = pwdata;
            if (query.valid && query.ready)
                predict_reply(query.data_byte, query.end_of_datagram);
            if (reply.valid && reply.ready) begin
                got = reply_of(reply.reply_byte, reply.byte_present,
                               reply.reply_done, reply.reply_abort);
                if (reply_due.size() == 0) begin
                    flag_mismatch("transaction with none outstanding", '0, got);
                end else begin
                    want = reply_due.pop_front();
                    if (got !== want)
                        flag_mismatch("mismatch", want, got);
                end
            end
        end
        pending = reply_due.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS responder testbench
// Drives query datagrams and answer address settings into the responder,
// with random idling on both channels, and reports the verdict of the reply
// checker at the end of the run.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] ADDR_ANSWER   = 3'd0;
    localparam int         MAX_BYTES     = dcr_pkg::MAX_DATAGRAM_BYTES_DEF;
    localparam int         HDR_BYTES     = dcr_pkg::HEADER_BYTES;
    localparam int         RANDOM_ITEMS  = 470;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         IDLE_PERCENT  = 34;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        steady;
    int          errors;
    int          pending;
    int          quiet;
    int          n_dgrams;
    int          n_bytes;
    int          n_good;
    int          n_bad;
    int          n_settings;
    logic [7:0]  dgram[$];

    dcr_query_if query_ch();
    dcr_reply_if reply_ch();

    dns_catchall_responder_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_ch),
        .reply   (reply_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dcr_reply_checker #(
        .MAX_BYTES  (MAX_BYTES),
        .ANSWER_REG (ADDR_ANSWER)
    ) reply_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_ch),
        .reply   (reply_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(negedge clk)
        reply_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk) begin
        if ((query_ch.valid && query_ch.ready) || (reply_ch.valid && reply_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            query_ch.valid <= 1'b0;
            @(negedge clk);
        end
        query_ch.valid           <= 1'b1;
        query_ch.data_byte       <= b;
        query_ch.end_of_datagram <= last;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        n_bytes++;
    endtask

    task automatic send_datagram();
        for (int i = 0; i < dgram.size(); i++)
            send_byte(dgram[i], i == dgram.size() - 1);
        n_dgrams++;
    endtask

    // Holds the sender back until every predicted reply transaction has arrived.
    task automatic settle();
        @(negedge clk);
        query_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_answer(input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ANSWER;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    task automatic push_bytes(input int count);
        for (int i = 0; i < count; i++)
            dgram.push_back(8'($urandom_range(255)));
    endtask

    task automatic trim_to(input int len);
        while (dgram.size() > len)
            void'(dgram.pop_back());
    endtask

    task automatic push_header(input logic resp, input logic qd_zero);
        logic [7:0] flags;
        logic [7:0] qd_hi;
        logic [7:0] qd_lo;
        flags    = 8'($urandom_range(255));
        flags[7] = resp;
        qd_hi    = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
        qd_lo    = 8'($urandom_range(255));
        if (qd_zero) begin
            qd_hi = 8'h00;
            qd_lo = 8'h00;
        end else if (qd_hi == 8'h00 && qd_lo == 8'h00) begin
            qd_lo = 8'h01;
        end
        push_bytes(2);
        dgram.push_back(flags);
        push_bytes(1);
        dgram.push_back(qd_hi);
        dgram.push_back(qd_lo);
        push_bytes(6);
    endtask

    task automatic push_name();
        int nlabels;
        int maxlen;
        int len;
        nlabels = $urandom_range(3);
        maxlen  = ($urandom_range(9) == 0) ? 63 : 12;
        for (int i = 0; i < nlabels; i++) begin
            len = $urandom_range(maxlen, 1);
            dgram.push_back(8'(len));
            push_bytes(len);
        end
        dgram.push_back(8'h00);
    endtask

    // Fills the name with labels so that its terminating zero lands at term_pos.
    task automatic fill_name_to(input int term_pos);
        int remaining;
        int chunk;
        remaining = term_pos - dgram.size();
        while (remaining > 0) begin
            chunk = (remaining >= 66) ? 64 : remaining;
            dgram.push_back(8'(chunk - 1));
            push_bytes(chunk - 1);
            remaining -= chunk;
        end
        dgram.push_back(8'h00);
    endtask

    task automatic random_datagram();
        int kind;
        dgram.delete();
        kind = $urandom_range(99);
        if (kind < 60) begin
            push_header(1'b0, 1'b0);
            push_name();
            push_bytes(4 + $urandom_range(3));
            n_good++;
        end else begin
            if (kind < 68) begin
                push_header(1'b0, 1'b0);
                trim_to($urandom_range(HDR_BYTES - 1, 1));
            end else if (kind < 74) begin
                push_header(1'b1, 1'b0);
                push_name();
                push_bytes(4);
            end else if (kind < 80) begin
                push_header(1'b0, 1'b1);
                push_name();
                push_bytes(4);
            end else if (kind < 90) begin
                push_header(1'b0, 1'b0);
                push_name();
                push_bytes(4);
                trim_to($urandom_range(dgram.size() - 1, HDR_BYTES + 1));
            end else begin
                push_bytes($urandom_range(40, 1));
            end
            n_bad++;
        end
        send_datagram();
    endtask

    initial begin
        int phase_start;
        rst_n                    = 1'b0;
        steady                   = 1'b0;
        quiet                    = 0;
        n_dgrams                 = 0;
        n_bytes                  = 0;
        n_good                   = 0;
        n_bad                    = 0;
        n_settings               = 0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        query_ch.valid           = 1'b0;
        query_ch.data_byte       = '0;
        query_ch.end_of_datagram = 1'b0;
        reply_ch.ready           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_answer(32'hFFFF_FFFF);

        // Shortest complete query: empty name, last byte on the final class byte.
        dgram = '{8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_datagram();
        n_good++;
        dgram = '{8'h00};
        send_datagram();
        dgram = '{8'h00, 8'h00, 8'h80};
        send_datagram();
        dgram = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
        send_datagram();
        n_bad += 3;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_answer(32'h0000_0000);
                1:       set_answer($urandom);
                2:       set_answer(32'h8000_0001);
                default: set_answer($urandom);
            endcase
            steady <= (ph == 2);
            phase_start = n_bytes;
            while (n_bytes - phase_start < RANDOM_ITEMS / 4)
                random_datagram();
        end
        steady <= 1'b0;

        set_answer(32'h0102_0304);
        // The question completes on the last position the block handles.
        dgram.delete();
        push_header(1'b0, 1'b0);
        fill_name_to(MAX_BYTES - 5);
        push_bytes(4 + 3);
        send_datagram();
        n_good++;
        // The question would end at the limit; bytes continue past the maximum.
        dgram.delete();
        push_header(1'b0, 1'b0);
        fill_name_to(MAX_BYTES - 4);
        push_bytes(MAX_BYTES + 8 - dgram.size());
        send_datagram();
        // The longest label, then a label that reaches exactly the limit.
        dgram.delete();
        push_header(1'b0, 1'b0);
        dgram.push_back(8'hFF);
        push_bytes(255);
        dgram.push_back(8'(MAX_BYTES - 1 - (HDR_BYTES + 256)));
        push_bytes(3);
        send_datagram();
        n_bad += 2;

        settle();
        $display("Run covered %0d datagrams (%0d query bytes): %0d complete queries, %0d cut short",
                 n_dgrams, n_bytes, n_good, n_bad);
        $display("or malformed, under %0d answer address settings, all ones and zero included.",
                 n_settings);
        if (errors == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dcr_pkg.sv
src/dcr_query_if.sv
src/dcr_reply_if.sv
src/dcr_front.sv
src/dcr_queue.sv
src/dcr_back.sv
src/dns_catchall_responder_core.sv
bench/dcr_reply_checker.sv
bench/tb.sv
